// File: src/hpmc_pkg.sv
// ---------------------------------------------------------------------------
// hpmc_pkg
// Shared constants, types and coordinate helpers of the half-pel predictor.
// ---------------------------------------------------------------------------
package hpmc_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;

  localparam int CRD_W = 13;
  localparam int MV_W  = 12;
  localparam int SMP_W = 8;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_PREDICT = 2'd1;
  localparam logic [1:0] OP_CONCEAL = 2'd2;

  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_U = 2'd1;
  localparam logic [1:0] PLANE_V = 2'd2;

  localparam logic [1:0] CS_GRAY  = 2'd0;
  localparam logic [1:0] CS_SLOT0 = 2'd1;
  localparam logic [1:0] CS_SLOT1 = 2'd2;

  localparam logic [1:0] DIR_BWD_ONLY = 2'd2;
  localparam logic [1:0] DIR_BOTH     = 2'd3;

  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_CONCEAL_SOURCE = 2'd2;

  localparam logic [SMP_W-1:0] GRAY_LEVEL = 8'd128;
  localparam logic [CRD_W-1:0] MIN_DIM    = 13'd16;

  typedef struct packed {
    logic             en;
    logic             slot;
    logic [1:0]       plane;
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [SMP_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic             en;
    logic             slot;
    logic [1:0]       plane;
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
  } store_rd_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] coord;
    logic                    half;
  } tap_t;

  // Integer position and half-pel flag for one vector component.
  function automatic tap_t split_coord(logic [6:0] pos, logic signed [MV_W-1:0] mv,
                                       logic chroma);
    logic signed [MV_W-1:0] v;
    logic signed [MV_W-1:0] step;
    tap_t                   r;
    v = chroma ? ((mv + $signed({11'b0, mv[MV_W-1]})) >>> 1) : mv;
    step = v >>> 1;
    r.half = v[0];
    r.coord = $signed({6'b0, pos}) + $signed({step[MV_W-1], step});
    return r;
  endfunction

  function automatic logic [CRD_W-1:0] clamp_coord(logic signed [CRD_W-1:0] v,
                                                   logic [CRD_W-1:0] lim);
    logic [CRD_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(lim)) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: src/hpmc_store.sv
// ---------------------------------------------------------------------------
// hpmc_store
// Reference frame memories: luma and chroma, one write and one read port,
// registered read data.
// ---------------------------------------------------------------------------
module hpmc_store
  import hpmc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  store_wr_t        wr,
  input  store_rd_t        rd,
  output logic [SMP_W-1:0] rdata
);

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int CXW    = $clog2(MAX_WIDTH / 2);
  localparam int CYW    = $clog2(MAX_HEIGHT / 2);
  localparam int LAW    = 1 + YW + XW;
  localparam int CAW    = 2 + CYW + CXW;
  localparam int LDEPTH = 1 << LAW;
  localparam int CDEPTH = 1 << CAW;

  localparam logic [CRD_W-1:0] LUMA_W   = CRD_W'(MAX_WIDTH);
  localparam logic [CRD_W-1:0] LUMA_H   = CRD_W'(MAX_HEIGHT);
  localparam logic [CRD_W-1:0] CHROMA_W = CRD_W'(MAX_WIDTH / 2);
  localparam logic [CRD_W-1:0] CHROMA_H = CRD_W'(MAX_HEIGHT / 2);

  logic [SMP_W-1:0] luma_mem   [LDEPTH];
  logic [SMP_W-1:0] chroma_mem [CDEPTH];

  logic [LAW-1:0]   luma_waddr;
  logic [CAW-1:0]   chroma_waddr;
  logic [LAW-1:0]   luma_raddr;
  logic [CAW-1:0]   chroma_raddr;
  logic             luma_we;
  logic             chroma_we;
  logic [SMP_W-1:0] luma_q;
  logic [SMP_W-1:0] chroma_q;
  logic             rd_luma;

  assign luma_waddr   = {wr.slot, wr.y[YW-1:0], wr.x[XW-1:0]};
  assign chroma_waddr = {wr.slot, wr.plane[1], wr.y[CYW-1:0], wr.x[CXW-1:0]};
  assign luma_raddr   = {rd.slot, rd.y[YW-1:0], rd.x[XW-1:0]};
  assign chroma_raddr = {rd.slot, rd.plane[1], rd.y[CYW-1:0], rd.x[CXW-1:0]};

  assign luma_we = wr.en && (wr.plane == PLANE_Y) && (wr.x < LUMA_W) && (wr.y < LUMA_H);
  assign chroma_we = wr.en && ((wr.plane == PLANE_U) || (wr.plane == PLANE_V)) &&
                     (wr.x < CHROMA_W) && (wr.y < CHROMA_H);

  always_ff @(posedge clk) begin
    if (luma_we) begin
      luma_mem[luma_waddr] <= wr.data;
    end
    if (rd.en) begin
      luma_q <= luma_mem[luma_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (chroma_we) begin
      chroma_mem[chroma_waddr] <= wr.data;
    end
    if (rd.en) begin
      chroma_q <= chroma_mem[chroma_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_luma <= (rd.plane == PLANE_Y);
    end
  end

  assign rdata = rd_luma ? luma_q : chroma_q;

endmodule

// File: src/halfpel_motion_comp_predictor.sv
// ---------------------------------------------------------------------------
// halfpel_motion_comp_predictor
// Half-pel motion compensated sample predictor over two reference frames.
// ---------------------------------------------------------------------------
// Write request: no result, the input stays ready. Predict/conceal: n reference
//   reads, one per cycle on the single store read port, n = 1, 2 or 4 per
//   direction (up to 8 bidirectional); read data is registered in the store,
//   the result formed in S_WAIT and issued from S_DONE. Gray conceal: no reads.
// A result not yet taken holds the next one back in its last cycle.
// Reset clears control and registers (128, 128, 0); memories are not reset.
module halfpel_motion_comp_predictor
  import hpmc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // ref_slot, plane, pos_x, pos_y, sample_in, direction,
  // mv_fwd_x, mv_fwd_y, mv_bwd_x, mv_bwd_y, zero pad
  input  logic [79:0] s_tdata,
  // op
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pred_sample
  output logic [7:0]  m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [CRD_W-1:0] MAXW = CRD_W'(MAX_WIDTH);
  localparam logic [CRD_W-1:0] MAXH = CRD_W'(MAX_HEIGHT);

  logic [7:0] frame_width;
  logic [7:0] frame_height;
  logic [1:0] conceal_source;

  logic [1:0] state;

  logic                   in_slot;
  logic [1:0]             in_plane;
  logic [6:0]             in_x;
  logic [6:0]             in_y;
  logic [SMP_W-1:0]       in_sample;
  logic [1:0]             in_dir;
  logic signed [MV_W-1:0] in_fx;
  logic signed [MV_W-1:0] in_fy;
  logic signed [MV_W-1:0] in_bx;
  logic signed [MV_W-1:0] in_by;
  logic                   accept;
  logic                   in_chroma;

  tap_t sf_x, sf_y, sb_x, sb_y, sz_x, sz_y;

  logic                    a_slot, b_slot;
  logic signed [CRD_W-1:0] a_x, a_y, b_x, b_y;
  logic                    a_hx, a_hy, b_hx, b_hy;
  logic                    two_pass;
  logic [1:0]              cur_plane;
  logic                    pass;
  logic [1:0]              k;

  logic                    cur_slot, cur_hx, cur_hy;
  logic signed [CRD_W-1:0] cur_x, cur_y, tx, ty;
  logic [1:0]              last_k;
  logic                    dx, dy;
  logic                    tap_last, final_tap;
  logic [CRD_W-1:0]        w_luma, h_luma, lim_x, lim_y;

  logic                    rd_pend, rd_tap_last, rd_final;
  logic [1:0]              rd_shift;
  logic [9:0]              acc, sum, rounded;
  logic [7:0]              pval, p0, res;
  logic [8:0]              bi_sum;
  logic [7:0]              fin;

  store_wr_t        wr;
  store_rd_t        rd;
  logic [SMP_W-1:0] rdata;

  assign in_slot   = s_tdata[0];
  assign in_plane  = s_tdata[2:1];
  assign in_x      = s_tdata[9:3];
  assign in_y      = s_tdata[16:10];
  assign in_sample = s_tdata[24:17];
  assign in_dir    = s_tdata[26:25];
  assign in_fx     = $signed(s_tdata[38:27]);
  assign in_fy     = $signed(s_tdata[50:39]);
  assign in_bx     = $signed(s_tdata[62:51]);
  assign in_by     = $signed(s_tdata[74:63]);

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign in_chroma = (in_plane != PLANE_Y);

  assign sf_x = split_coord(in_x, in_fx, in_chroma);
  assign sf_y = split_coord(in_y, in_fy, in_chroma);
  assign sb_x = split_coord(in_x, in_bx, in_chroma);
  assign sb_y = split_coord(in_y, in_by, in_chroma);
  assign sz_x = split_coord(in_x, '0, in_chroma);
  assign sz_y = split_coord(in_y, '0, in_chroma);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= 8'd128;
      frame_height   <= 8'd128;
      conceal_source <= CS_GRAY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:    frame_width    <= cfg_data;
        REG_FRAME_HEIGHT:   frame_height   <= cfg_data;
        REG_CONCEAL_SOURCE: conceal_source <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Plane limits from the saturated frame size.
  always_comb begin
    if ({5'b0, frame_width} < MIN_DIM) begin
      w_luma = MIN_DIM;
    end else if ({5'b0, frame_width} > MAXW) begin
      w_luma = MAXW;
    end else begin
      w_luma = {5'b0, frame_width};
    end
    if ({5'b0, frame_height} < MIN_DIM) begin
      h_luma = MIN_DIM;
    end else if ({5'b0, frame_height} > MAXH) begin
      h_luma = MAXH;
    end else begin
      h_luma = {5'b0, frame_height};
    end
    lim_x = (cur_plane == PLANE_Y) ? w_luma - 1'b1 : (w_luma >> 1) - 1'b1;
    lim_y = (cur_plane == PLANE_Y) ? h_luma - 1'b1 : (h_luma >> 1) - 1'b1;
  end

  // Tap sequencing: 1, 2 or 4 taps per direction.
  assign cur_slot  = pass ? b_slot : a_slot;
  assign cur_x     = pass ? b_x : a_x;
  assign cur_y     = pass ? b_y : a_y;
  assign cur_hx    = pass ? b_hx : a_hx;
  assign cur_hy    = pass ? b_hy : a_hy;
  assign last_k    = {cur_hx & cur_hy, cur_hx | cur_hy};
  assign dx        = cur_hx & k[0];
  assign dy        = cur_hy & (cur_hx ? k[1] : k[0]);
  assign tx        = cur_x + $signed({12'b0, dx});
  assign ty        = cur_y + $signed({12'b0, dy});
  assign tap_last  = (k == last_k);
  assign final_tap = tap_last && (pass || !two_pass);

  assign rd.en    = (state == S_RD);
  assign rd.slot  = cur_slot;
  assign rd.plane = cur_plane;
  assign rd.x     = clamp_coord(tx, lim_x);
  assign rd.y     = clamp_coord(ty, lim_y);

  assign wr.en    = accept && (s_tuser == OP_WRITE);
  assign wr.slot  = in_slot;
  assign wr.plane = in_plane;
  assign wr.x     = {6'b0, in_x};
  assign wr.y     = {6'b0, in_y};
  assign wr.data  = in_sample;

  hpmc_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_store (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  // Tap accumulation and rounding.
  assign sum     = acc + {2'b0, rdata};
  assign rounded = sum + ((10'd1 << rd_shift) >> 1);
  assign pval    = 8'(rounded >> rd_shift);
  assign bi_sum  = {1'b0, p0} + {1'b0, pval} + 9'd1;
  assign fin     = two_pass ? bi_sum[8:1] : pval;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pass     <= 1'b0;
      k        <= '0;
      rd_pend  <= 1'b0;
      acc      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      rd_pend     <= (state == S_RD);
      rd_tap_last <= tap_last;
      rd_final    <= final_tap;
      rd_shift    <= {cur_hx & cur_hy, cur_hx ^ cur_hy};

      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      if (rd_pend) begin
        if (rd_tap_last) begin
          acc <= '0;
          if (!rd_final) begin
            p0 <= pval;
          end
        end else begin
          acc <= sum;
        end
      end

      case (state)
        S_IDLE: begin
          if (accept && (in_plane <= PLANE_V)) begin
            cur_plane <= in_plane;
            pass      <= 1'b0;
            k         <= '0;
            b_slot    <= 1'b1;
            b_x       <= sb_x.coord;
            b_y       <= sb_y.coord;
            b_hx      <= sb_x.half;
            b_hy      <= sb_y.half;
            case (s_tuser)
              OP_PREDICT: begin
                two_pass <= (in_dir == DIR_BOTH);
                if (in_dir == DIR_BWD_ONLY) begin
                  a_slot <= 1'b1;
                  a_x    <= sb_x.coord;
                  a_y    <= sb_y.coord;
                  a_hx   <= sb_x.half;
                  a_hy   <= sb_y.half;
                end else begin
                  a_slot <= 1'b0;
                  a_x    <= sf_x.coord;
                  a_y    <= sf_y.coord;
                  a_hx   <= sf_x.half;
                  a_hy   <= sf_y.half;
                end
                state <= S_RD;
              end
              OP_CONCEAL: begin
                two_pass <= 1'b0;
                a_slot   <= conceal_source[1];
                a_x      <= sz_x.coord;
                a_y      <= sz_y.coord;
                a_hx     <= 1'b0;
                a_hy     <= 1'b0;
                if ((conceal_source == CS_SLOT0) || (conceal_source == CS_SLOT1)) begin
                  state <= S_RD;
                end else begin
                  res   <= GRAY_LEVEL;
                  state <= S_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          if (tap_last) begin
            k <= '0;
            if (final_tap) begin
              state <= S_WAIT;
            end else begin
              pass <= 1'b1;
            end
          end else begin
            k <= k + 2'd1;
          end
        end
        S_WAIT: begin
          if (rd_pend && rd_final) begin
            res   <= fin;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/hpmc_checker.sv
// ---------------------------------------------------------------------------
// hpmc_checker
// Port-level checks of the half-pel predictor, bound to the top level.
// ---------------------------------------------------------------------------
module hpmc_checker
  import hpmc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [79:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  logic in_req;
  logic plane_ok;

  assign in_req   = s_tvalid && s_tready;
  assign plane_ok = (s_tdata[2:1] <= PLANE_V);

  // Stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A predict or conceal request occupies the block.
  assert property (@(posedge clk) disable iff (rst)
    in_req && plane_ok && ((s_tuser == OP_PREDICT) || (s_tuser == OP_CONCEAL))
    |=> !s_tready)
    else $error("request taken while a prediction is busy");

  // A write request leaves the input ready.
  assert property (@(posedge clk) disable iff (rst)
    in_req && (s_tuser == OP_WRITE) |=> s_tready)
    else $error("write request stalled the input");

  // A new result only leaves a busy block.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a request in progress");

endmodule

bind halfpel_motion_comp_predictor hpmc_checker u_hpmc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: verif/hpmc_pred_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hpmc_pred_checker
// Watches the request, result and register channels of the half-pel
// predictor, keeps shadow reference frames and registers, works out the
// sample each predict or conceal request must give and compares it with
// the results in order.
// ---------------------------------------------------------------------------
module hpmc_pred_checker
  import hpmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          outstanding,
  output int          mismatches
);

  localparam int LUMA_W   = DEF_MAX_WIDTH;
  localparam int LUMA_H   = DEF_MAX_HEIGHT;
  localparam int CHROMA_W = LUMA_W / 2;
  localparam int CHROMA_H = LUMA_H / 2;
  localparam int MIN_SIDE = 16;

  logic [7:0] ref_luma   [2][LUMA_H][LUMA_W];
  logic [7:0] ref_chroma [2][2][CHROMA_H][CHROMA_W];
  logic [7:0] frame_w;
  logic [7:0] frame_h;
  logic [1:0] conceal_src;
  logic [7:0] pred_sample_q [$];

  initial begin
    outstanding = 0;
    mismatches  = 0;
  end

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Edge-clamped reference read.
  function automatic int ref_at(bit slot, logic [1:0] plane, int x, int y);
    int w;
    int h;
    w = clip(int'(frame_w), MIN_SIDE, LUMA_W);
    h = clip(int'(frame_h), MIN_SIDE, LUMA_H);
    if (plane == PLANE_Y) begin
      return int'(ref_luma[slot][clip(y, 0, h - 1)][clip(x, 0, w - 1)]);
    end
    return int'(ref_chroma[slot][plane - 1][clip(y, 0, h / 2 - 1)][clip(x, 0, w / 2 - 1)]);
  endfunction

  // One-direction half-pel sample; chroma vector is luma / 2 toward zero.
  function automatic int dir_sample(bit slot, logic [1:0] plane, int px, int py,
                                    int mvx, int mvy);
    int vx;
    int vy;
    int hx;
    int hy;
    int a;
    vx = (plane == PLANE_Y) ? mvx : mvx / 2;
    vy = (plane == PLANE_Y) ? mvy : mvy / 2;
    hx = vx & 1;
    hy = vy & 1;
    px += (vx - hx) / 2;
    py += (vy - hy) / 2;
    a = ref_at(slot, plane, px, py);
    if (hx == 0 && hy == 0) return a;
    if (hy == 0) return (a + ref_at(slot, plane, px + 1, py) + 1) >> 1;
    if (hx == 0) return (a + ref_at(slot, plane, px, py + 1) + 1) >> 1;
    return (a + ref_at(slot, plane, px + 1, py) + ref_at(slot, plane, px, py + 1)
            + ref_at(slot, plane, px + 1, py + 1) + 2) >> 2;
  endfunction

  always @(posedge clk) begin : monitor
    logic [1:0] op;
    logic [1:0] plane;
    logic [1:0] dir;
    logic       slot;
    logic [7:0] expected;
    int         px;
    int         py;
    int         fx;
    int         fy;
    int         bx;
    int         by;
    int         res;
    if (rst) begin
      frame_w     = 8'd128;
      frame_h     = 8'd128;
      conceal_src = CS_GRAY;
      pred_sample_q.delete();
    end else begin
      // results first: a result never belongs to a request taken at the same edge
      if (m_tvalid && m_tready) begin
        if (pred_sample_q.size() == 0) begin
          $error("pred_sample: result %0d with no request waiting", m_tdata);
          mismatches++;
        end else begin
          expected = pred_sample_q.pop_front();
          if (m_tdata !== expected) begin
            $error("pred_sample mismatch: expected %0d, actual %0d", expected, m_tdata);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:    frame_w = cfg_data;
          REG_FRAME_HEIGHT:   frame_h = cfg_data;
          REG_CONCEAL_SOURCE: conceal_src = cfg_data[1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        op    = s_tuser;
        slot  = s_tdata[0];
        plane = s_tdata[2:1];
        px    = int'(s_tdata[9:3]);
        py    = int'(s_tdata[16:10]);
        dir   = s_tdata[26:25];
        fx    = int'($signed(s_tdata[38:27]));
        fy    = int'($signed(s_tdata[50:39]));
        bx    = int'($signed(s_tdata[62:51]));
        by    = int'($signed(s_tdata[74:63]));
        if (plane <= PLANE_V) begin
          case (op)
            OP_WRITE: begin
              if (plane == PLANE_Y) begin
                ref_luma[slot][py][px] = s_tdata[24:17];
              end else if (px < CHROMA_W && py < CHROMA_H) begin
                ref_chroma[slot][plane - 1][py][px] = s_tdata[24:17];
              end
            end
            OP_PREDICT: begin
              if (dir == DIR_BOTH) begin
                res = (dir_sample(1'b0, plane, px, py, fx, fy)
                       + dir_sample(1'b1, plane, px, py, bx, by) + 1) >> 1;
              end else if (dir == DIR_BWD_ONLY) begin
                res = dir_sample(1'b1, plane, px, py, bx, by);
              end else begin
                res = dir_sample(1'b0, plane, px, py, fx, fy);
              end
              pred_sample_q.push_back(res[7:0]);
            end
            OP_CONCEAL: begin
              case (conceal_src)
                CS_SLOT0: res = dir_sample(1'b0, plane, px, py, 0, 0);
                CS_SLOT1: res = dir_sample(1'b1, plane, px, py, 0, 0);
                default:  res = int'(GRAY_LEVEL);
              endcase
              pred_sample_q.push_back(res[7:0]);
            end
            default: ;
          endcase
        end
      end
    end
    outstanding <= pred_sample_q.size();
  end

endmodule

// File: verif/halfpel_motion_comp_predictor_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// halfpel_motion_comp_predictor_tb
// Fills the part of both reference frames that a smallest-size frame reads,
// runs directed edge requests, then random write, predict and conceal
// traffic over frame sizes at and below the smallest one and several conceal
// sources with random stalls on both sides; a checker predicts each sample.
// ---------------------------------------------------------------------------
module halfpel_motion_comp_predictor_tb;
  import hpmc_pkg::*;

  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         DRAIN_CYCLES   = 20;
  localparam int         HALF_ITEMS     = 70;
  localparam logic [7:0] FILL_SIDE      = 8'd16;
  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic [1:0] PLANE_NONE     = 2'd3;
  localparam logic [1:0] CS_RESERVED    = 2'd3;
  localparam logic [1:0] DIR_NONE       = 2'd0;
  localparam logic [1:0] DIR_FWD_ONLY   = 2'd1;

  // reads stay inside the filled corner: every size here saturates to 16
  localparam logic [7:0] FRAME_W_SET [6] = '{8'd16, 8'd0, 8'd15, 8'd1, 8'd8, 8'd16};
  localparam logic [7:0] FRAME_H_SET [6] = '{8'd16, 8'd16, 8'd0, 8'd12, 8'd3, 8'd9};
  localparam logic [1:0] CS_SET [6] = '{CS_SLOT0, CS_SLOT1, CS_GRAY, CS_RESERVED,
                                        CS_SLOT0, CS_SLOT1};
  localparam int SEND_IDLE_SET [3] = '{29, 55, 0};
  localparam int RECV_IDLE_SET [3] = '{55, 29, 0};

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data  = '0;

  int outstanding;
  int mismatches;
  int send_idle = 0;
  int recv_idle = 0;
  int stall_cycles = 0;

  halfpel_motion_comp_predictor u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hpmc_pred_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog: consecutive cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("halfpel_motion_comp_predictor regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [79:0] pack_request(logic slot, logic [1:0] plane, logic [6:0] x,
                                               logic [6:0] y, logic [7:0] sample,
                                               logic [1:0] dir, int fx, int fy,
                                               int bx, int by);
    logic [11:0] fx12;
    logic [11:0] fy12;
    logic [11:0] bx12;
    logic [11:0] by12;
    fx12 = fx[11:0];
    fy12 = fy[11:0];
    bx12 = bx[11:0];
    by12 = by[11:0];
    return {5'b0, by12, bx12, fy12, fx12, dir, sample, y, x, plane, slot};
  endfunction

  function automatic int rand_mv();
    case ($urandom_range(9))
      0: return int'($urandom_range(4095)) - 2048;
      1: begin
        case ($urandom_range(3))
          0: return -2048;
          1: return 2047;
          2: return -1;
          default: return 1;
        endcase
      end
      default: return int'($urandom_range(64)) - 32;
    endcase
  endfunction

  task automatic issue_request(input logic [1:0] op, input logic [79:0] data);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic issue_predict(input logic [1:0] plane, input logic [6:0] x, input logic [6:0] y,
                               input logic [1:0] dir, input int fx, input int fy,
                               input int bx, input int by);
    issue_request(OP_PREDICT, pack_request(1'b0, plane, x, y, 8'd0, dir, fx, fy, bx, by));
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    s_tvalid <= 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request(output bit counted);
    logic [1:0] op;
    logic [1:0] plane;
    logic [6:0] x;
    logic [6:0] y;
    int         pick;
    pick    = $urandom_range(99);
    plane   = 2'($urandom_range(2));
    x       = 7'($urandom_range(127));
    y       = 7'($urandom_range(127));
    counted = 1'b1;
    if (pick < 15) begin
      op = OP_WRITE;
      if (plane != PLANE_Y) begin
        if ($urandom_range(7) != 0) begin
          x[6] = 1'b0;
          y[6] = 1'b0;
        end
        counted = !x[6] && !y[6];
      end
    end else if (pick < 80) begin
      op = OP_PREDICT;
    end else if (pick < 93) begin
      op = OP_CONCEAL;
    end else begin
      counted = 1'b0;
      if ($urandom_range(1)) begin
        op = OP_UNUSED;
      end else begin
        op    = 2'($urandom_range(2));
        plane = PLANE_NONE;
      end
    end
    issue_request(op, pack_request(1'($urandom_range(1)), plane, x, y,
                                   8'($urandom_range(255)), 2'($urandom_range(3)),
                                   rand_mv(), rand_mv(), rand_mv(), rand_mv()));
  endtask

  initial begin
    int  sel;
    int  done_items;
    bit  counted;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every reference entry that a 16 by 16 frame reads is written first
    for (int slot = 0; slot < 2; slot++) begin
      for (int y = 0; y < FILL_SIDE; y++) begin
        for (int x = 0; x < FILL_SIDE; x++) begin
          issue_request(OP_WRITE, pack_request(1'(slot), PLANE_Y, 7'(x), 7'(y),
                                               8'($urandom_range(255)), DIR_NONE,
                                               0, 0, 0, 0));
        end
      end
      for (int p = 1; p <= 2; p++) begin
        for (int y = 0; y < FILL_SIDE / 2; y++) begin
          for (int x = 0; x < FILL_SIDE / 2; x++) begin
            issue_request(OP_WRITE, pack_request(1'(slot), 2'(p), 7'(x), 7'(y),
                                                 8'($urandom_range(255)), DIR_NONE,
                                                 0, 0, 0, 0));
          end
        end
      end
    end

    // directed requests: gray conceal at reset values, then the filled frame size
    issue_request(OP_CONCEAL, pack_request(1'b0, PLANE_Y, 7'd5, 7'd9, 8'd0, DIR_NONE,
                                           0, 0, 0, 0));
    write_reg(REG_FRAME_WIDTH, FILL_SIDE);
    write_reg(REG_FRAME_HEIGHT, FILL_SIDE);
    issue_predict(PLANE_Y, 7'd0, 7'd0, DIR_FWD_ONLY, 0, 0, 0, 0);
    issue_predict(PLANE_Y, 7'd127, 7'd127, DIR_FWD_ONLY, 1, 1, 0, 0);
    issue_predict(PLANE_Y, 7'd30, 7'd40, DIR_FWD_ONLY, 1, 0, 0, 0);
    issue_predict(PLANE_Y, 7'd30, 7'd40, DIR_BWD_ONLY, 0, 0, 0, 1);
    issue_predict(PLANE_Y, 7'd64, 7'd64, DIR_BWD_ONLY, 0, 0, -2048, -2048);
    issue_predict(PLANE_Y, 7'd64, 7'd64, DIR_BOTH, 2047, 2047, 2047, -2048);
    issue_predict(PLANE_U, 7'd10, 7'd10, DIR_BOTH, -1, -3, 3, -5);
    issue_predict(PLANE_V, 7'd20, 7'd33, DIR_NONE, 3, 5, 0, 0);
    issue_predict(PLANE_U, 7'd0, 7'd63, DIR_FWD_ONLY, 2047, -2048, 0, 0);
    issue_predict(PLANE_V, 7'd127, 7'd127, DIR_BOTH, -7, 9, 7, -9);
    // stores inside and outside the chroma area, then read back the corner
    issue_request(OP_WRITE, pack_request(1'b0, PLANE_U, 7'd64, 7'd5, 8'hAA, DIR_NONE,
                                         0, 0, 0, 0));
    issue_request(OP_WRITE, pack_request(1'b1, PLANE_Y, 7'd15, 7'd15, 8'hFF, DIR_NONE,
                                         0, 0, 0, 0));
    issue_request(OP_WRITE, pack_request(1'b0, PLANE_V, 7'd7, 7'd7, 8'h00, DIR_NONE,
                                         0, 0, 0, 0));
    issue_predict(PLANE_Y, 7'd127, 7'd127, DIR_BWD_ONLY, 0, 0, 0, 0);
    issue_predict(PLANE_V, 7'd63, 7'd63, DIR_FWD_ONLY, 0, 0, 0, 0);
    issue_predict(PLANE_U, 7'd63, 7'd5, DIR_FWD_ONLY, 0, 0, 0, 0);
    // plane three and op three are dropped
    issue_request(OP_WRITE, pack_request(1'b0, PLANE_NONE, 7'd1, 7'd1, 8'h55, DIR_NONE,
                                         0, 0, 0, 0));
    issue_predict(PLANE_NONE, 7'd1, 7'd1, DIR_BOTH, 1, 1, 1, 1);
    issue_request(OP_CONCEAL, pack_request(1'b0, PLANE_NONE, 7'd1, 7'd1, 8'd0, DIR_NONE,
                                           0, 0, 0, 0));
    issue_request(OP_UNUSED, pack_request(1'b1, PLANE_Y, 7'd2, 7'd2, 8'h12, DIR_BOTH,
                                          1, 1, 1, 1));
    // conceal under each source
    write_reg(REG_CONCEAL_SOURCE, {6'b0, CS_SLOT0});
    issue_request(OP_CONCEAL, pack_request(1'b0, PLANE_Y, 7'd127, 7'd0, 8'd0, DIR_NONE,
                                           5, 5, 5, 5));
    write_reg(REG_CONCEAL_SOURCE, {6'b0, CS_SLOT1});
    issue_request(OP_CONCEAL, pack_request(1'b0, PLANE_U, 7'd100, 7'd3, 8'd0, DIR_NONE,
                                           0, 0, 0, 0));
    write_reg(REG_CONCEAL_SOURCE, {6'b0, CS_RESERVED});
    issue_request(OP_CONCEAL, pack_request(1'b0, PLANE_V, 7'd4, 7'd4, 8'd0, DIR_NONE,
                                           0, 0, 0, 0));

    // random traffic, two register settings per idling profile
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = SEND_IDLE_SET[ph];
      recv_idle = RECV_IDLE_SET[ph];
      for (int half = 0; half < 2; half++) begin
        sel = ph * 2 + half;
        write_reg(REG_FRAME_WIDTH, FRAME_W_SET[sel]);
        write_reg(REG_FRAME_HEIGHT, FRAME_H_SET[sel]);
        write_reg(REG_CONCEAL_SOURCE, {6'b0, CS_SET[sel]});
        done_items = 0;
        while (done_items < HALF_ITEMS) begin
          random_request(counted);
          if (counted) done_items++;
        end
      end
    end

    s_tvalid <= 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("halfpel_motion_comp_predictor regression: pass");
    end else begin
      $display("halfpel_motion_comp_predictor regression: fail");
    end
    $finish;
  end

endmodule

// File: halfpel_motion_comp_predictor.f
src/hpmc_pkg.sv
src/hpmc_store.sv
src/halfpel_motion_comp_predictor.sv
src/hpmc_checker.sv
verif/hpmc_pred_checker.sv
verif/halfpel_motion_comp_predictor_tb.sv
